### sv/wgm_pkg.sv
// Shared constants and types for the wildcard glob matcher.
package wgm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int IDX_W = $clog2(PATTERN_MAX);
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int SYM_W = 8;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT = 1'b1;

	localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
	localparam logic [SYM_W-1:0] QMARK_BYTE = 8'h3F;
	localparam logic [SYM_W-1:0] DOT_BYTE = 8'h2E;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic fresh;
		logic step;
	} wgm_ctl_t;

	typedef struct packed {
		logic eff;
		logic cl;
	} wgm_tap_t;

endpackage

### sv/wgm_if.sv
// Valid/ready channel interfaces for the matcher input and result words.
interface wgm_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [wgm_pkg::SYM_W-1:0] symbol;
	logic last;

	modport source (output valid, output cmd, output symbol, output last, input ready);
	modport sink (input valid, input cmd, input symbol, input last, output ready);
endinterface

interface wgm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

### sv/wgm_cell.sv
// One pattern position: stored byte, active bit and its link in the closure chain.
module wgm_cell (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic used,
	input logic lead_in,
	input logic h_in,
	input wgm_pkg::wgm_ctl_t ctl,
	output logic lead_out,
	output logic h_out,
	output wgm_pkg::wgm_tap_t tap
);
	import wgm_pkg::*;

	logic [SYM_W-1:0] byte_q;
	logic star_q;
	logic qmark_q;
	logic lead_q;
	logic act_q;
	logic eff;
	logic hit;
	logic adv;
	logic stay;
	logic cl;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byte_q <= ctl.sym;
			star_q <= (ctl.sym == STAR_BYTE);
			qmark_q <= (ctl.sym == QMARK_BYTE);
			lead_q <= lead_in & (ctl.sym == STAR_BYTE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (ctl.step) begin
			act_q <= cl;
		end
	end

	always_comb begin
		eff = ctl.fresh ? lead_in : act_q;
		hit = star_q | (qmark_q & (ctl.sym != DOT_BYTE)) | (byte_q == ctl.sym);
		adv = eff & used & hit;
		stay = eff & used & star_q;
		cl = h_in | stay;
		h_out = adv | (cl & used & star_q);
	end

	assign lead_out = lead_q;
	assign tap = '{eff: eff, cl: cl};

endmodule

### sv/wildcard_glob_matcher.sv
// Top level of the glob matcher: pattern store as a row of position cells.
//
//   channel  dir  word fields                       result
//   in_ch    in   cmd, symbol, last                 pattern or text byte
//   out_ch   out  matched, pattern_overflow         one word per text end
//
// One input word is taken every cycle unless the output stalls; a text byte
// moves the active set through the combinational chain of position cells.
// The result word for a last text byte is registered and shows in the next cycle.
// A waiting result does not stall input unless the output is still full and
// not being taken. Reset clears length and flags (sets fresh) and the output valid bit.
module wildcard_glob_matcher (
	input logic clk,
	input logic arst_n,
	wgm_in_if.sink in_ch,
	wgm_out_if.source out_ch
);
	import wgm_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic complete_q;
	logic ovf_q;
	logic fresh_q;
	logic act_end_q;
	logic out_valid_q;
	logic matched_q;
	logic ovf_out_q;

	logic accept;
	logic take;
	logic has_sym;
	logic is_pat;
	logic is_txt;
	logic [LEN_W-1:0] len_base;
	logic ovf_base;
	logic room;
	logic wr_en;
	logic res_valid;
	logic res_matched;
	wgm_ctl_t ctl;

	logic [PATTERN_MAX:0] lead;
	logic [PATTERN_MAX:0] h;
	logic [PATTERN_MAX:0] cl_vec;
	logic [PATTERN_MAX:0] eff_vec;
	logic [PATTERN_MAX-1:0] used;
	wgm_tap_t tap [PATTERN_MAX];

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;
	assign has_sym = (in_ch.symbol != '0);
	assign take = accept && (has_sym || in_ch.last);
	assign is_pat = take && (in_ch.cmd == CMD_PATTERN);
	assign is_txt = take && (in_ch.cmd == CMD_TEXT);

	assign len_base = complete_q ? '0 : len_q;
	assign ovf_base = complete_q ? 1'b0 : ovf_q;
	assign room = (len_base < LEN_W'(PATTERN_MAX));
	assign wr_en = is_pat && has_sym && room;

	assign ctl.sym = in_ch.symbol;
	assign ctl.fresh = fresh_q;
	assign ctl.step = is_txt && has_sym && !in_ch.last;

	assign lead[0] = 1'b1;
	assign h[0] = 1'b0;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		assign used[i] = (LEN_W'(i) < len_q);

		wgm_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.wr_en(wr_en && (len_base[IDX_W-1:0] == IDX_W'(i))),
			.used(used[i]),
			.lead_in(lead[i]),
			.h_in(h[i]),
			.ctl(ctl),
			.lead_out(lead[i+1]),
			.h_out(h[i+1]),
			.tap(tap[i])
		);

		assign cl_vec[i] = tap[i].cl;
		assign eff_vec[i] = tap[i].eff;
	end

	assign cl_vec[PATTERN_MAX] = h[PATTERN_MAX];
	assign eff_vec[PATTERN_MAX] = fresh_q ? lead[PATTERN_MAX] : act_end_q;

	assign res_valid = is_txt && in_ch.last;
	assign res_matched = (has_sym ? cl_vec[len_q] : eff_vec[len_q]) && !ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			complete_q <= 1'b0;
			ovf_q <= 1'b0;
			fresh_q <= 1'b1;
			act_end_q <= 1'b0;
		end else begin
			if (is_pat) begin
				len_q <= len_base + LEN_W'(wr_en);
				ovf_q <= ovf_base || (has_sym && !room);
				complete_q <= in_ch.last;
				fresh_q <= 1'b1;
			end else if (is_txt) begin
				if (in_ch.last) begin
					fresh_q <= 1'b1;
				end else begin
					fresh_q <= 1'b0;
				end
			end
			if (ctl.step) begin
				act_end_q <= cl_vec[PATTERN_MAX];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			matched_q <= res_matched;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.matched = matched_q;
	assign out_ch.pattern_overflow = ovf_out_q;

endmodule
